[design/addressable_led_bit_encoder_macros.svh]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder assertion macros
// Concurrent check wrappers; they compile to nothing under synthesis.
// ----------------------------------------------------------------------------
`ifndef ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH
`define ADDRESSABLE_LED_BIT_ENCODER_MACROS_SVH

`ifndef SYNTHESIS
// check on every clock edge while out of reset
`define ALED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// check on every clock edge, reset included
`define ALED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define ALED_ASSERT(label, prop, msg)
`define ALED_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[design/aled_pkg.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder package
// Shared widths, register codes, queue entry and status types.
// ----------------------------------------------------------------------------
package aled_pkg;

  localparam int ChannelBits = 8;
  localparam int WordBits    = 3 * ChannelBits;
  localparam int CountBits   = $clog2(WordBits);
  localparam int CfgIdxBits  = 2;
  localparam int OrderBits   = 6;

  // divide by 255*255 through a reciprocal: floor(2^32 / 65025)
  localparam int unsigned FullScaleSq = 65025;
  localparam int unsigned RecipMul    = 66051;
  localparam int          RecipShift  = 32;
  localparam int          ProdBits    = 3 * ChannelBits;
  localparam int          RecipBits   = ProdBits + 17;

  localparam logic [ChannelBits-1:0] GlobalBrightnessRst = 8'd255;
  localparam logic [ChannelBits-1:0] PulseOneRst         = 8'd208;
  localparam logic [ChannelBits-1:0] PulseZeroRst        = 8'd104;

  localparam int QueueDepthDefault = 2;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_GLOBAL_BRIGHTNESS = 2'd0,
    REG_PULSE_ONE_WIDTH   = 2'd1,
    REG_PULSE_ZERO_WIDTH  = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ORD_RED     = 2'd0,
    ORD_GREEN   = 2'd1,
    ORD_BLUE    = 2'd2,
    ORD_RED_ALT = 2'd3
  } order_code_e;

  typedef enum logic [1:0] {
    PH_MUL_STRIP  = 2'd0,
    PH_MUL_GLOBAL = 2'd1,
    PH_RECIP      = 2'd2,
    PH_CORRECT    = 2'd3
  } scale_phase_e;

  typedef enum logic [1:0] {
    FR_IDLE  = 2'd0,
    FR_SCALE = 2'd1,
    FR_PUSH  = 2'd2
  } front_state_e;

  typedef struct packed {
    logic [WordBits-1:0] word;
    logic                blank;
  } queue_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[design/aled_ifs.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder channels
// Valid/ready channels for LED items in and bit slot pulses out.
// ----------------------------------------------------------------------------
interface aled_in_if import aled_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ChannelBits-1:0] red;
  logic [ChannelBits-1:0] green;
  logic [ChannelBits-1:0] blue;
  logic [OrderBits-1:0]   channel_order;
  logic [ChannelBits-1:0] strip_brightness;
  logic                   blank;

  modport source (output valid, red, green, blue, channel_order, strip_brightness, blank,
                  input ready);
  modport sink   (input valid, red, green, blue, channel_order, strip_brightness, blank,
                  output ready);
endinterface

interface aled_out_if import aled_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ChannelBits-1:0] pulse_width;
  logic                   last_bit;

  modport source (output valid, pulse_width, last_bit, input ready);
  modport sink   (input valid, pulse_width, last_bit, output ready);
endinterface

[design/aled_front.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder front end
// Accepts an LED item, scales a colour item's three ordered channels in turn
// through a shared multiply / reciprocal-divide sequence, queues the word.
// ----------------------------------------------------------------------------
module aled_front import aled_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  aled_in_if.sink                item_i,
  input  logic [ChannelBits-1:0] global_brightness_i,
  input  queue_status_t          q_status_i,
  output logic                   push_o,
  output queue_entry_t           entry_o
);

  front_state_e state_q, state_d;
  scale_phase_e phase_q;
  logic [1:0]   slot_q;

  logic [ChannelBits-1:0]   red_q, green_q, blue_q, strip_q;
  logic [OrderBits-1:0]     order_q;
  logic                     blank_q;
  logic [2*ChannelBits-1:0] p1_q;
  logic [ProdBits-1:0]      prod_q;
  logic [ChannelBits-1:0]   quot_q;
  logic [WordBits-1:0]      word_q;

  logic                     accept;
  logic                     last_slot;
  logic [ChannelBits-1:0]   sel_val;
  logic [1:0]               code;
  logic [RecipBits-1:0]     recip_prod;
  logic [ProdBits-1:0]      quot_back;
  logic [ProdBits-1:0]      rem;
  logic [ChannelBits-1:0]   quot_fix;

  assign accept    = item_i.valid && item_i.ready;
  assign last_slot = (slot_q == 2'd2) && (phase_q == PH_CORRECT);

  // pick the order code of the current slot, lowest field first
  always_comb begin
    case (slot_q)
      2'd0:    code = order_q[1:0];
      2'd1:    code = order_q[3:2];
      default: code = order_q[5:4];
    endcase
    case (order_code_e'(code))
      ORD_GREEN: sel_val = green_q;
      ORD_BLUE:  sel_val = blue_q;
      default:   sel_val = red_q;
    endcase
  end

  assign recip_prod = RecipBits'(prod_q) * RecipBits'(RecipMul);
  assign quot_back  = ProdBits'(quot_q) * ProdBits'(FullScaleSq);
  assign rem        = prod_q - quot_back;
  // reciprocal estimate is at most one low
  assign quot_fix   = (rem >= ProdBits'(FullScaleSq)) ? quot_q + 1'b1 : quot_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      FR_IDLE: begin
        if (accept) state_d = item_i.blank ? FR_PUSH : FR_SCALE;
      end
      FR_SCALE: begin
        if (last_slot) state_d = FR_PUSH;
      end
      FR_PUSH: begin
        if (!q_status_i.full) state_d = FR_IDLE;
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready = (state_q == FR_IDLE);
    push_o       = (state_q == FR_PUSH) && !q_status_i.full;
    entry_o      = '{word: word_q, blank: blank_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      phase_q <= PH_MUL_STRIP;
      slot_q  <= 2'd0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        phase_q <= PH_MUL_STRIP;
        slot_q  <= 2'd0;
      end else if (state_q == FR_SCALE) begin
        phase_q <= scale_phase_e'(2'(phase_q + 2'd1));
        if (phase_q == PH_CORRECT) slot_q <= 2'(slot_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      red_q   <= item_i.red;
      green_q <= item_i.green;
      blue_q  <= item_i.blue;
      order_q <= item_i.channel_order;
      strip_q <= item_i.strip_brightness;
      blank_q <= item_i.blank;
      word_q  <= '0;
    end else if (state_q == FR_SCALE) begin
      case (phase_q)
        PH_MUL_STRIP:  p1_q   <= (2*ChannelBits)'(sel_val) * (2*ChannelBits)'(strip_q);
        PH_MUL_GLOBAL: prod_q <= ProdBits'(p1_q) * ProdBits'(global_brightness_i);
        PH_RECIP:      quot_q <= recip_prod[RecipShift +: ChannelBits];
        PH_CORRECT:    word_q <= {word_q[WordBits-ChannelBits-1:0], quot_fix};
        default:       quot_q <= quot_q;
      endcase
    end
  end

endmodule

[design/aled_queue.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder word queue
// Small FIFO of scaled words between the front end and the bit serializer.
// ----------------------------------------------------------------------------
module aled_queue import aled_pkg::*; #(
  parameter int Depth = QueueDepthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  queue_entry_t  entry_i,
  input  logic          pop_i,
  output queue_entry_t  entry_o,
  output queue_status_t status_o
);

  localparam int PtrBits = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits = $clog2(Depth + 1);

  queue_entry_t        mem_q [Depth];
  logic [PtrBits-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]  count_q;

  function automatic logic [PtrBits-1:0] next_ptr(input logic [PtrBits-1:0] ptr);
    logic [PtrBits-1:0] nxt;
    nxt = (ptr == PtrBits'(Depth - 1)) ? '0 : PtrBits'(ptr + 1'b1);
    return nxt;
  endfunction

  assign entry_o        = mem_q[rd_ptr_q];
  assign status_o.full  = (count_q == CntBits'(Depth));
  assign status_o.empty = (count_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= next_ptr(wr_ptr_q);
      if (pop_i)  rd_ptr_q <= next_ptr(rd_ptr_q);
      if (push_i && !pop_i)      count_q <= CntBits'(count_q + 1'b1);
      else if (pop_i && !push_i) count_q <= CntBits'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= entry_i;
  end

endmodule

[design/aled_back.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder serializer
// Shifts a queued word out MSB first, one timer compare value per transfer.
// ----------------------------------------------------------------------------
module aled_back import aled_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  queue_entry_t           entry_i,
  input  queue_status_t          q_status_i,
  output logic                   pop_o,
  input  logic [ChannelBits-1:0] pulse_one_width_i,
  input  logic [ChannelBits-1:0] pulse_zero_width_i,
  aled_out_if.source             pulse_o
);

  logic                 active_q;
  logic [CountBits-1:0] cnt_q;
  logic [WordBits-1:0]  word_q;
  logic                 blank_q;

  logic xfer;
  logic last;
  logic load;

  assign last = (cnt_q == CountBits'(WordBits - 1));
  assign xfer = pulse_o.valid && pulse_o.ready;
  // free after the final slot is taken
  assign load = !active_q || (xfer && last);
  assign pop_o = load && !q_status_i.empty;

  assign pulse_o.valid       = active_q;
  assign pulse_o.last_bit    = last;
  assign pulse_o.pulse_width = blank_q              ? '0 :
                               word_q[WordBits-1] ? pulse_one_width_i : pulse_zero_width_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (pop_o) begin
      active_q <= 1'b1;
      cnt_q    <= '0;
    end else if (load) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else if (xfer) begin
      cnt_q <= CountBits'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      word_q  <= entry_i.word;
      blank_q <= entry_i.blank;
    end else if (xfer) begin
      word_q <= {word_q[WordBits-2:0], 1'b0};
    end
  end

endmodule

[design/addressable_led_bit_encoder.sv]
// ----------------------------------------------------------------------------
// Addressable LED bit encoder
// Turns one LED item into 24 timer compare values, MSB of the first slot first.
// Usage: item_i takes red/green/blue, the 2-bit-per-slot channel order, strip
// brightness and blank; pulse_o gives pulse_width with last_bit on slot 24.
// Registers (cfg_we_i, cfg_idx_i, cfg_data_i): 0 global brightness, 1 one width,
// 2 zero width; write only while idle, other indexes are ignored.
// Path: a colour item passes serial scaling of its three channels, the queue
// push and the serializer load before its first pulse; a blank skips scaling.
// The serializer sends one slot per transfer and bounds the item rate; the
// front end takes a new item once the last one is pushed and runs ahead
// into the queue. Reset empties the queue, drops any pending pulses and
// restores register defaults 255, 208, 104. A stalled receiver holds the
// current pulse; the queue then fills and item_i.ready drops.
// ----------------------------------------------------------------------------
`include "addressable_led_bit_encoder_macros.svh"

module addressable_led_bit_encoder import aled_pkg::*; #(
  parameter int QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  aled_in_if.sink                item_i,
  aled_out_if.source             pulse_o,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_idx_i,
  input  logic [ChannelBits-1:0] cfg_data_i
);

  logic [ChannelBits-1:0] global_brightness_q;
  logic [ChannelBits-1:0] pulse_one_width_q;
  logic [ChannelBits-1:0] pulse_zero_width_q;

  queue_status_t q_status;
  queue_entry_t  push_entry, pop_entry;
  logic          push, pop;
  logic          item_xfer;
  logic          drain_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      global_brightness_q <= GlobalBrightnessRst;
      pulse_one_width_q   <= PulseOneRst;
      pulse_zero_width_q  <= PulseZeroRst;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_GLOBAL_BRIGHTNESS: global_brightness_q <= cfg_data_i;
        REG_PULSE_ONE_WIDTH:   pulse_one_width_q   <= cfg_data_i;
        REG_PULSE_ZERO_WIDTH:  pulse_zero_width_q  <= cfg_data_i;
        default:               global_brightness_q <= global_brightness_q;
      endcase
    end
  end

  aled_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .item_i              (item_i),
    .global_brightness_i (global_brightness_q),
    .q_status_i          (q_status),
    .push_o              (push),
    .entry_o             (push_entry)
  );

  aled_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .entry_o  (pop_entry),
    .status_o (q_status)
  );

  aled_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .entry_i            (pop_entry),
    .q_status_i         (q_status),
    .pop_o              (pop),
    .pulse_one_width_i  (pulse_one_width_q),
    .pulse_zero_width_i (pulse_zero_width_q),
    .pulse_o            (pulse_o)
  );

  assign item_xfer  = item_i.valid && item_i.ready;
  // final slot taken with nothing left to load
  assign drain_done = pulse_o.valid && pulse_o.ready && pulse_o.last_bit && q_status.empty;

  `ALED_ASSERT_ALWAYS(a_no_push_full, !(push && q_status.full), "push into full queue")
  `ALED_ASSERT_ALWAYS(a_no_pop_empty, !(pop && q_status.empty), "pop from empty queue")
  `ALED_ASSERT(a_busy_after_take, item_xfer |=> !item_i.ready, "front ready after transfer")
  `ALED_ASSERT(a_idle_after_last, drain_done |=> !pulse_o.valid, "pulse after final slot")

endmodule
